@@ sv/dual_pcm_fifo_audio_mixer_assert.svh @@
// assertion macros used by the mixer checker
`ifndef DUAL_PCM_FIFO_AUDIO_MIXER_ASSERT_SVH
`define DUAL_PCM_FIFO_AUDIO_MIXER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define DPFAM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define DPFAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dpfam_pkg.sv @@
// shared types, constants and helpers of the dual pcm fifo mixer
`default_nettype none
package dpfam_pkg;

   // fifo geometry; depth is a power of two and a multiple of the lane count
   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LANES      = 4;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ROW_DEPTH  = FIFO_DEPTH / LANES;
   localparam int ROW_W      = $clog2(ROW_DEPTH);
   localparam int LEVEL_W    = 6;
   localparam int CHANNELS   = 2;

   typedef logic [7:0]         byte_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [LANE_W-1:0]  lane_type;
   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [15:0]        ctrl_type;
   typedef logic signed [15:0] sample_type;

   localparam level_type FIFO_FULL     = LEVEL_W'(FIFO_DEPTH);
   localparam level_type DMA_THRESHOLD = LEVEL_W'(16);

   // request kinds
   localparam logic CMD_BUS_WRITE = 1'b0;
   localparam logic CMD_TIMER     = 1'b1;

   // access sizes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // register offsets inside the sound area
   localparam byte_type OFF_CTRL_L    = 8'h80;
   localparam byte_type OFF_CTRL_H    = 8'h82;
   localparam byte_type OFF_CTRL_H_HI = 8'h83;
   localparam byte_type OFF_FIFO_A    = 8'hA0;
   localparam byte_type OFF_FIFO_B    = 8'hA4;
   localparam byte_type OFF_FIFO_END  = 8'hA7;

   // sound control bit positions
   localparam int CTL_A_FULL  = 2;
   localparam int CTL_B_FULL  = 3;
   localparam int CTL_A_RIGHT = 8;
   localparam int CTL_A_LEFT  = 9;
   localparam int CTL_A_TIMER = 10;
   localparam int CTL_A_RESET = 11;
   localparam int CTL_B_RIGHT = 12;
   localparam int CTL_B_LEFT  = 13;
   localparam int CTL_B_TIMER = 14;
   localparam int CTL_B_RESET = 15;
   localparam ctrl_type CTL_RESET_MASK = 16'h8800;

   // per-request flags carried from the update stage to the mix stage
   typedef struct packed {
      logic [CHANNELS-1:0] pop;
      logic [CHANNELS-1:0] clr;
      logic [CHANNELS-1:0] dma;
      level_type           level_a;
      level_type           level_b;
      ctrl_type            ctrl;
      logic                master;
   } stage_type;

   // latch contribution: latch * 256, or latch * 128 at half volume
   function automatic sample_type chan_value(input byte_type held, input logic full);
      sample_type v;
      if (full) begin
         v = {held, 8'h00};
      end else begin
         v = {held[7], held, 7'h00};
      end
      return v;
   endfunction

   // saturate a two-term sum to 16 bits
   function automatic sample_type sat16(input logic signed [16:0] v);
      sample_type r;
      if (v > 17'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -17'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = sample_type'(v[15:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/dpfam_if.sv @@
// handshake channels of the dual pcm fifo mixer
`default_nettype none

// request channel: bus writes and timer overflows
interface dpfam_req_if;
   import dpfam_pkg::*;
   logic      valid;
   logic      ready;
   logic      cmd;
   logic [1:0] access_size;
   byte_type  bus_offset;
   logic [31:0] write_data;
   logic [1:0] timer_id;
   modport source (output valid, cmd, access_size, bus_offset, write_data, timer_id,
                   input ready);
   modport sink   (input valid, cmd, access_size, bus_offset, write_data, timer_id,
                   output ready);
endinterface

// response channel: mixed samples and fifo status
interface dpfam_rsp_if;
   import dpfam_pkg::*;
   logic       valid;
   logic       ready;
   sample_type left_sample;
   sample_type right_sample;
   logic       dma_request_a;
   logic       dma_request_b;
   level_type  level_a;
   level_type  level_b;
   modport source (output valid, left_sample, right_sample, dma_request_a,
                   dma_request_b, level_a, level_b, input ready);
   modport sink   (input valid, left_sample, right_sample, dma_request_a,
                   dma_request_b, level_a, level_b, output ready);
endinterface

// control write channel: master enable
interface dpfam_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/dpfam_fifo_bank.sv @@
// byte storage of one fifo, split into four lanes with registered read
`default_nettype none
module dpfam_fifo_bank (
   input  wire                   clock,
   input  wire [dpfam_pkg::LANES-1:0] wr_en,
   input  dpfam_pkg::row_type    wr_row [dpfam_pkg::LANES],
   input  dpfam_pkg::byte_type   wr_data [dpfam_pkg::LANES],
   input  wire                   rd_en,
   input  dpfam_pkg::ptr_type    rd_ptr,
   output dpfam_pkg::byte_type   rd_data
);
   import dpfam_pkg::*;

   byte_type lane_q_ff [LANES];
   lane_type lane_sel_ff;

   // one memory per lane: one write and one read a cycle each
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      byte_type mem [ROW_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en[l]) begin
            mem[wr_row[l]] <= wr_data[l];
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            lane_q_ff[l] <= mem[rd_ptr[PTR_W-1:LANE_W]];
         end
      end
   end

   // remember which lane the pointer addressed
   always_ff @(posedge clock) begin
      if (rd_en) begin
         lane_sel_ff <= rd_ptr[LANE_W-1:0];
      end
   end

   assign rd_data = lane_q_ff[lane_sel_ff];

endmodule
`default_nettype wire

@@ sv/dual_pcm_fifo_audio_mixer.sv @@
// An accepted request passes through the stage 1 register, the stage 2 register and the
// response register before its response is shown.
// Throughput: one request per cycle while the response side takes results.
// A full response register stalls the whole pipeline through req ready.
// The fifo byte read goes through a registered lane memory, hence the mix stage.
// Reset (synchronous, active high) empties both fifos, zeroes latches, control and enable.
`default_nettype none
module dual_pcm_fifo_audio_mixer (
   input wire           clock,
   input wire           reset,
   dpfam_req_if.sink    req_if,
   dpfam_rsp_if.source  rsp_if,
   dpfam_csr_if.sink    csr_if
);
   import dpfam_pkg::*;

   // pipeline control
   logic advance;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   // stage 1 request register
   logic       s1_cmd_ff;
   logic [1:0] s1_size_ff;
   byte_type   s1_off_ff;
   logic [31:0] s1_data_ff;
   logic [1:0] s1_timer_ff;

   // architectural state
   ctrl_type  ctrl_ff, ctrl_in;
   ptr_type   rp_ff  [CHANNELS];
   ptr_type   rp_in  [CHANNELS];
   level_type lvl_ff [CHANNELS];
   level_type lvl_in [CHANNELS];
   byte_type  held_ff [CHANNELS];
   byte_type  held_in [CHANNELS];
   logic      master_ff;

   // stage 2 register
   stage_type s2_ff, s2_in;

   // response register
   sample_type left_ff, right_ff;
   logic       dma_a_ff, dma_b_ff;
   level_type  level_a_ff, level_b_ff;

   // stage 1 decode
   logic      is_write, size_ok, in_window, push_ch, ld_en;
   ctrl_type  ld_val;
   logic [2:0] nbytes;
   logic [CHANNELS-1:0] push_en, match, pop, clr, dma, sel_bit;
   ptr_type   tail [CHANNELS];
   level_type room [CHANNELS];
   level_type pushed [CHANNELS];
   logic [LANES-1:0] wr_en [CHANNELS];
   row_type   wr_row [CHANNELS][LANES];
   byte_type  wr_data [CHANNELS][LANES];
   byte_type  rd_data [CHANNELS];

   // stage 2 mix
   logic signed [16:0] left_sum, right_sum;
   sample_type val_a, val_b;

   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = advance;
   assign csr_if.ready  = 1'b1;

   // valid bits of the three registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_if.valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff   <= req_if.cmd;
         s1_size_ff  <= req_if.access_size;
         s1_off_ff   <= req_if.bus_offset;
         s1_data_ff  <= req_if.write_data;
         s1_timer_ff <= req_if.timer_id;
      end
   end

   // master enable
   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= 1'b0;
      end else if (csr_if.valid) begin
         master_ff <= csr_if.data;
      end
   end

   // write decode
   always_comb begin
      is_write  = (s1_cmd_ff == CMD_BUS_WRITE);
      size_ok   = (s1_size_ff == SIZE_BYTE) || (s1_size_ff == SIZE_HALF) ||
                  (s1_size_ff == SIZE_WORD);
      in_window = (s1_off_ff >= OFF_FIFO_A) && (s1_off_ff <= OFF_FIFO_END);
      push_ch   = (s1_off_ff >= OFF_FIFO_B);
      nbytes    = 3'd1 << s1_size_ff;
   end

   // control register loads
   always_comb begin
      ld_en  = 1'b0;
      ld_val = ctrl_ff;
      if (is_write && !in_window) begin
         case (s1_size_ff)
            SIZE_BYTE: begin
               if (s1_off_ff == OFF_CTRL_H) begin
                  ld_en  = 1'b1;
                  ld_val = {ctrl_ff[15:8], s1_data_ff[7:0]};
               end else if (s1_off_ff == OFF_CTRL_H_HI) begin
                  ld_en  = 1'b1;
                  ld_val = {s1_data_ff[7:0], ctrl_ff[7:0]};
               end
            end
            SIZE_HALF: begin
               if (s1_off_ff == OFF_CTRL_H) begin
                  ld_en  = 1'b1;
                  ld_val = s1_data_ff[15:0];
               end
            end
            SIZE_WORD: begin
               if (s1_off_ff == OFF_CTRL_L) begin
                  ld_en  = 1'b1;
                  ld_val = s1_data_ff[31:16];
               end
            end
            default: begin
            end
         endcase
      end
      ctrl_in   = ld_en ? (ld_val & ~CTL_RESET_MASK) : ctrl_ff;
      clr[0]    = ld_en && ld_val[CTL_A_RESET];
      clr[1]    = ld_en && ld_val[CTL_B_RESET];
      sel_bit[0] = ctrl_ff[CTL_A_TIMER];
      sel_bit[1] = ctrl_ff[CTL_B_TIMER];
   end

   // per channel push, pop and pointer update
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         push_en[ch] = is_write && size_ok && in_window && (push_ch == 1'(ch));
         tail[ch]    = rp_ff[ch] + lvl_ff[ch][PTR_W-1:0];
         room[ch]    = FIFO_FULL - lvl_ff[ch];
         pushed[ch]  = (LEVEL_W'(nbytes) > room[ch]) ? room[ch] : LEVEL_W'(nbytes);
         match[ch]   = !is_write && master_ff && (s1_timer_ff == {1'b0, sel_bit[ch]});
         pop[ch]     = match[ch] && (lvl_ff[ch] != '0);
         rp_in[ch]   = rp_ff[ch];
         lvl_in[ch]  = lvl_ff[ch];
         if (clr[ch]) begin
            rp_in[ch]  = '0;
            lvl_in[ch] = '0;
         end else if (push_en[ch]) begin
            lvl_in[ch] = lvl_ff[ch] + pushed[ch];
         end else if (pop[ch]) begin
            rp_in[ch]  = rp_ff[ch] + PTR_W'(1);
            lvl_in[ch] = lvl_ff[ch] - LEVEL_W'(1);
         end
         dma[ch] = match[ch] && (lvl_in[ch] <= DMA_THRESHOLD);
      end
   end

   // lane steering: byte i of the write lands at tail + i
   always_comb begin
      lane_type off;
      ptr_type  addr;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int l = 0; l < LANES; l++) begin
            off  = LANE_W'(l) - tail[ch][LANE_W-1:0];
            addr = tail[ch] + PTR_W'(off);
            wr_en[ch][l]   = advance && s1_valid_ff && push_en[ch] &&
                             (LEVEL_W'(off) < pushed[ch]);
            wr_row[ch][l]  = addr[PTR_W-1:LANE_W];
            wr_data[ch][l] = byte_type'(s1_data_ff >> {off, 3'b000});
         end
      end
   end

   // fifo storage
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_bank
      dpfam_fifo_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_en[ch]),
         .wr_row  (wr_row[ch]),
         .wr_data (wr_data[ch]),
         .rd_en   (advance && s1_valid_ff && pop[ch]),
         .rd_ptr  (rp_ff[ch]),
         .rd_data (rd_data[ch])
      );
   end

   // state update at the end of stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            rp_ff[ch]  <= '0;
            lvl_ff[ch] <= '0;
         end
      end else if (advance && s1_valid_ff) begin
         ctrl_ff <= ctrl_in;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            rp_ff[ch]  <= rp_in[ch];
            lvl_ff[ch] <= lvl_in[ch];
         end
      end
   end

   // flags handed to the mix stage
   always_comb begin
      s2_in.pop     = pop;
      s2_in.clr     = clr;
      s2_in.dma     = dma;
      s2_in.level_a = lvl_in[0];
      s2_in.level_b = lvl_in[1];
      s2_in.ctrl    = ctrl_in;
      s2_in.master  = master_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   // latch update with the byte read in stage 1
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (s2_ff.clr[ch]) begin
            held_in[ch] = '0;
         end else if (s2_ff.pop[ch]) begin
            held_in[ch] = rd_data[ch];
         end else begin
            held_in[ch] = held_ff[ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            held_ff[ch] <= '0;
         end
      end else if (advance && s2_valid_ff) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            held_ff[ch] <= held_in[ch];
         end
      end
   end

   // left and right mix with saturation
   always_comb begin
      val_a     = chan_value(held_in[0], s2_ff.ctrl[CTL_A_FULL]);
      val_b     = chan_value(held_in[1], s2_ff.ctrl[CTL_B_FULL]);
      left_sum  = '0;
      right_sum = '0;
      if (s2_ff.master) begin
         if (s2_ff.ctrl[CTL_A_LEFT]) begin
            left_sum = left_sum + 17'(val_a);
         end
         if (s2_ff.ctrl[CTL_B_LEFT]) begin
            left_sum = left_sum + 17'(val_b);
         end
         if (s2_ff.ctrl[CTL_A_RIGHT]) begin
            right_sum = right_sum + 17'(val_a);
         end
         if (s2_ff.ctrl[CTL_B_RIGHT]) begin
            right_sum = right_sum + 17'(val_b);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff    <= sat16(left_sum);
         right_ff   <= sat16(right_sum);
         dma_a_ff   <= s2_ff.dma[0];
         dma_b_ff   <= s2_ff.dma[1];
         level_a_ff <= s2_ff.level_a;
         level_b_ff <= s2_ff.level_b;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.left_sample   = left_ff;
   assign rsp_if.right_sample  = right_ff;
   assign rsp_if.dma_request_a = dma_a_ff;
   assign rsp_if.dma_request_b = dma_b_ff;
   assign rsp_if.level_a       = level_a_ff;
   assign rsp_if.level_b       = level_b_ff;

endmodule
`default_nettype wire

@@ sv/dpfam_checker.sv @@
// port-level checks of the mixer response channel, bound to the top level
`default_nettype none
`include "dual_pcm_fifo_audio_mixer_assert.svh"
module dpfam_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input dpfam_pkg::sample_type  left_sample,
   input dpfam_pkg::sample_type  right_sample,
   input wire                    dma_request_a,
   input wire                    dma_request_b,
   input dpfam_pkg::level_type   level_a,
   input dpfam_pkg::level_type   level_b
);
   import dpfam_pkg::*;

   // levels never pass the fifo depth
   `DPFAM_ASSERT_NOW(a_level_range, clock, reset, rsp_valid, (level_a <= FIFO_FULL) && (level_b <= FIFO_FULL), "fifo level above depth")

   // a refill request only comes with a low fifo
   `DPFAM_ASSERT_NOW(a_dma_a_low, clock, reset, rsp_valid && dma_request_a, level_a <= DMA_THRESHOLD, "dma request a with level above threshold")
   `DPFAM_ASSERT_NOW(a_dma_b_low, clock, reset, rsp_valid && dma_request_b, level_b <= DMA_THRESHOLD, "dma request b with level above threshold")

   // a stalled response stays and holds its samples and levels
   `DPFAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `DPFAM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(left_sample) && $stable(right_sample) && $stable(level_a) && $stable(level_b), "response changed while stalled")

endmodule

bind dual_pcm_fifo_audio_mixer dpfam_checker u_dpfam_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .left_sample   (rsp_if.left_sample),
   .right_sample  (rsp_if.right_sample),
   .dma_request_a (rsp_if.dma_request_a),
   .dma_request_b (rsp_if.dma_request_b),
   .level_a       (rsp_if.level_a),
   .level_b       (rsp_if.level_b)
);
`default_nettype wire
